/* rtl/modular_inverse_macros.svh */
// ---------------------------------------------------------------------------
// Modular inverse assertion macros
// Shared concurrent assertion forms used by the modular inverse RTL.
// ---------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_MACROS_SVH
`define MODULAR_INVERSE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("modular_inverse: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("modular_inverse: assertion failed");

`endif

/* rtl/mi_pkg.sv */
// ---------------------------------------------------------------------------
// Modular inverse package
// Default width and the command and status bundles between the controller
// and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package mi_pkg;

   localparam int MOD_BITS_DEFAULT = 31;
   localparam int MOD_RESET_VALUE  = 2;

   typedef struct packed {
      logic load;
      logic start;
      logic shift_up;
      logic div_step;
      logic update;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic lo_zero;
      logic can_shift;
      logic last_bit;
   } dp_status_type;

endpackage

`default_nettype wire

/* rtl/modular_inverse.sv */
// ---------------------------------------------------------------------------
// Modular inverse
// Extended Euclidean inverse of a value modulo the configured modulus.
// ---------------------------------------------------------------------------
//   Channel   Ports                                  Direction
//   request   req_valid, req_ready, req_value         in
//   response  rsp_valid, rsp_ready, rsp_inverse       out
//   config    csr_write_enable, csr_write_data        in
//
// One request is worked at a time; each quotient step aligns the divisor by doublings and then
// runs the one-bit-per-cycle shift-subtract divider back down.
// A response is registered after the last quotient step and the final reduction; the next
// request can be taken while that response still waits to be accepted.
// Reset sets the modulus to 2 and empties the block.
// A finished result waits in the output register; the final reduction stalls until it is free.
// ---------------------------------------------------------------------------
`default_nettype none

module modular_inverse #(
   parameter int MOD_BITS = mi_pkg::MOD_BITS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_write_enable,
   input  wire logic [MOD_BITS-1:0] csr_write_data,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [MOD_BITS-1:0] req_value,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic      [MOD_BITS-1:0] rsp_inverse
);
   import mi_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   mi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mi_datapath #(
      .MOD_BITS (MOD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_value        (req_value),
      .cmd              (cmd),
      .status           (status),
      .rsp_inverse      (rsp_inverse)
   );

endmodule

`default_nettype wire

/* rtl/mi_datapath.sv */
// ---------------------------------------------------------------------------
// Modular inverse datapath
// Remainder pair, Bezout coefficients, shift-subtract divider with an
// accumulated quotient product, final reduction and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module mi_datapath #(
   parameter int MOD_BITS = mi_pkg::MOD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [MOD_BITS-1:0]   csr_write_data,
   input  wire logic [MOD_BITS-1:0]   req_value,
   input  wire mi_pkg::dp_cmd_type    cmd,
   output mi_pkg::dp_status_type      status,
   output logic      [MOD_BITS-1:0]   rsp_inverse
);
   import mi_pkg::*;

   localparam int CW = MOD_BITS + 2;
   localparam int KW = $clog2(MOD_BITS);

   logic        [MOD_BITS-1:0] mod_ff, mod_in;
   logic        [MOD_BITS-1:0] hi_ff, hi_in;
   logic        [MOD_BITS-1:0] lo_ff, lo_in;
   logic        [MOD_BITS-1:0] r_ff, r_in;
   logic        [MOD_BITS-1:0] d_ff, d_in;
   logic        [KW-1:0]       k_ff, k_in;
   logic signed [CW-1:0]       cprev_ff, cprev_in;
   logic signed [CW-1:0]       ccur_ff, ccur_in;
   logic signed [CW-1:0]       acc_ff, acc_in;
   logic        [MOD_BITS-1:0] inv_ff, inv_in;

   logic        [MOD_BITS:0]   d_dbl;
   logic                       r_ge_d;
   logic signed [CW-1:0]       acc_step;
   logic signed [CW-1:0]       mod_ext;
   logic signed [CW-1:0]       reduced;

   always_comb begin
      d_dbl    = {d_ff, 1'b0};
      r_ge_d   = r_ff >= d_ff;
      acc_step = (acc_ff <<< 1) + (r_ge_d ? ccur_ff : CW'(0));
      mod_ext  = CW'(mod_ff);
      if (cprev_ff[CW-1]) begin
         reduced = cprev_ff + mod_ext;
      end else if (cprev_ff >= mod_ext) begin
         reduced = cprev_ff - mod_ext;
      end else begin
         reduced = cprev_ff;
      end

      status.lo_zero   = lo_ff == '0;
      status.can_shift = d_dbl <= {1'b0, r_ff};
      status.last_bit  = k_ff == '0;
   end

   always_comb begin
      mod_in   = mod_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      r_in     = r_ff;
      d_in     = d_ff;
      k_in     = k_ff;
      cprev_in = cprev_ff;
      ccur_in  = ccur_ff;
      acc_in   = acc_ff;
      inv_in   = inv_ff;

      if (csr_write_enable) begin
         mod_in = csr_write_data;
      end
      if (cmd.load) begin
         hi_in    = mod_ff;
         lo_in    = req_value;
         cprev_in = '0;
         ccur_in  = CW'(1);
      end
      if (cmd.start) begin
         r_in   = hi_ff;
         d_in   = lo_ff;
         k_in   = '0;
         acc_in = '0;
      end
      if (cmd.shift_up) begin
         d_in = d_dbl[MOD_BITS-1:0];
         k_in = k_ff + KW'(1);
      end
      if (cmd.div_step) begin
         if (r_ge_d) begin
            r_in = r_ff - d_ff;
         end
         acc_in = acc_step;
         d_in   = d_ff >> 1;
         k_in   = k_ff - KW'(1);
      end
      if (cmd.update) begin
         hi_in    = lo_ff;
         lo_in    = r_ff;
         cprev_in = ccur_ff;
         ccur_in  = cprev_ff - acc_ff;
      end
      if (cmd.finish) begin
         inv_in = (mod_ff == '0) ? '0 : reduced[MOD_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= MOD_BITS'(MOD_RESET_VALUE);
      end else begin
         mod_ff <= mod_in;
      end
      hi_ff    <= hi_in;
      lo_ff    <= lo_in;
      r_ff     <= r_in;
      d_ff     <= d_in;
      k_ff     <= k_in;
      cprev_ff <= cprev_in;
      ccur_ff  <= ccur_in;
      acc_ff   <= acc_in;
      inv_ff   <= inv_in;
   end

   assign rsp_inverse = inv_ff;

endmodule

`default_nettype wire

/* rtl/mi_ctrl.sv */
// ---------------------------------------------------------------------------
// Modular inverse controller
// Sequences the Euclid steps, the divider alignment and subtraction phases,
// and the request and response handshakes.
// ---------------------------------------------------------------------------
`default_nettype none

`include "modular_inverse_macros.svh"

module mi_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire mi_pkg::dp_status_type status,
   output mi_pkg::dp_cmd_type         cmd
);
   import mi_pkg::*;

   typedef enum logic [5:0] {
      IDLE_ST   = 6'b000001,
      CHECK_ST  = 6'b000010,
      ALIGN_ST  = 6'b000100,
      DIVIDE_ST = 6'b001000,
      UPDATE_ST = 6'b010000,
      REDUCE_ST = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      req_ready    = state_ff == IDLE_ST;

      case (state_ff)
         IDLE_ST: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK_ST;
            end
         end
         CHECK_ST: begin
            if (status.lo_zero) begin
               state_in = REDUCE_ST;
            end else begin
               cmd.start = 1'b1;
               state_in  = ALIGN_ST;
            end
         end
         ALIGN_ST: begin
            if (status.can_shift) begin
               cmd.shift_up = 1'b1;
            end else begin
               state_in = DIVIDE_ST;
            end
         end
         DIVIDE_ST: begin
            cmd.div_step = 1'b1;
            if (status.last_bit) begin
               state_in = UPDATE_ST;
            end
         end
         UPDATE_ST: begin
            cmd.update = 1'b1;
            state_in   = CHECK_ST;
         end
         REDUCE_ST: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = IDLE_ST;
            end
         end
         default: begin
            state_in = IDLE_ST;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE_ST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `MI_ASSERT_SAME(a_no_overwrite, clock, reset, cmd.finish, !rsp_valid_ff || rsp_ready)
   `MI_ASSERT_NEXT(a_accept_check, clock, reset, req_valid && req_ready, state_ff == CHECK_ST)
   `MI_ASSERT_NEXT(a_divide_done, clock, reset, state_ff == DIVIDE_ST && status.last_bit,
                   state_ff == UPDATE_ST)
   `MI_ASSERT_NEXT(a_align_done, clock, reset, state_ff == ALIGN_ST && !status.can_shift,
                   state_ff == DIVIDE_ST)

endmodule

`default_nettype wire

/* tb/sv/tb_modular_inverse.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Modular inverse testbench
// Sends values to the inverse block under a range of moduli, predicts each
// inverse with an extended Euclid model of its own, and compares every
// response in order while both sides idle and stall at random in most phases.
// ---------------------------------------------------------------------------

module tb_modular_inverse;

   localparam int W = mi_pkg::MOD_BITS_DEFAULT;
   localparam logic [W-1:0] MOD_MAX = {W{1'b1}};

   class inverse_scoreboard;
      logic [W-1:0] modulus_setting;
      logic [W-1:0] expected_inverses[$];
      int error_count;

      function new();
         modulus_setting = W'(mi_pkg::MOD_RESET_VALUE);
         error_count = 0;
      endfunction

      function void set_modulus(logic [W-1:0] m);
         modulus_setting = m;
      endfunction

      function int pending();
         return expected_inverses.size();
      endfunction

      function logic [W-1:0] expected_inverse(logic [W-1:0] v);
         logic [63:0] m;
         logic [63:0] rem_a;
         logic [63:0] rem_b;
         logic [63:0] coef_old;
         logic [63:0] coef_new;
         logic [63:0] quot;
         logic [63:0] tmp;
         logic [63:0] mag;
         m = 64'(modulus_setting);
         rem_a = m;
         rem_b = 64'(v);
         coef_old = 64'd0;
         coef_new = 64'd1;
         if (m == 64'd0) return '0;
         while (rem_b != 64'd0) begin
            quot = rem_a / rem_b;
            tmp = rem_a % rem_b;
            rem_a = rem_b;
            rem_b = tmp;
            tmp = coef_old - quot * coef_new;
            coef_old = coef_new;
            coef_new = tmp;
         end
         if (!coef_old[63]) return W'(coef_old % m);
         mag = 64'd0 - coef_old;
         tmp = mag % m;
         return (tmp == 64'd0) ? '0 : W'(m - tmp);
      endfunction

      function void note_request(logic [W-1:0] v);
         expected_inverses.push_back(expected_inverse(v));
      endfunction

      task report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
         $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
         error_count++;
      endtask

      task check_inverse(logic [W-1:0] got);
         logic [W-1:0] want;
         if (expected_inverses.size() == 0) begin
            report_mismatch("unexpected response", got, '0);
         end else begin
            want = expected_inverses.pop_front();
            if (got !== want) report_mismatch("inverse", got, want);
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [W-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [W-1:0] rsp_inverse;

   inverse_scoreboard sb = new();
   bit idle_enabled = 1'b1;
   bit hold_off_pending = 1'b0;
   logic [W-1:0] active_modulus = W'(mi_pkg::MOD_RESET_VALUE);

   modular_inverse #(.MOD_BITS(W)) u_top (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_inverse(rsp_inverse)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   task automatic send_value(input logic [W-1:0] v);
      int gap;
      if (idle_enabled && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 17);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(v);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_modulus(input logic [W-1:0] m);
      drain_responses();
      csr_write_enable <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_modulus = m;
      sb.set_modulus(m);
   endtask

   function automatic logic [W-1:0] pick_value(logic [W-1:0] m);
      logic [W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = W'($urandom_range(0, 3));
         1, 7: v = W'($urandom);
         2, 3, 4: v = W'($urandom % m);
         5: v = m + W'($urandom_range(0, 2)) - W'(1);
         default: v = W'($urandom % m) & ~W'(1);
      endcase
      return v;
   endfunction

   // Response side: random stall bursts, plus one long hold-off on request.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) sb.check_inverse(rsp_inverse);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            hold_left = 800;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 17) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [W-1:0] m;
      logic [W-1:0] lost;
      int phase;
      int n;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset modulus, largest prime, shared factors, tiny and zero moduli.
      send_value('0);
      send_value(W'(1));
      send_value(W'(2));
      send_value(W'(3));
      send_value(MOD_MAX);
      write_modulus(MOD_MAX);
      send_value('0);
      send_value(W'(1));
      send_value(W'(2));
      send_value(MOD_MAX - W'(1));
      send_value(MOD_MAX);
      send_value(W'(31'h4000_0000));
      send_value(W'(31'h5555_5555));
      send_value(W'(31'h2AAA_AAAA));
      write_modulus(W'(1000000));
      send_value(W'(10));
      send_value(W'(250000));
      send_value(W'(999999));
      send_value(W'(1000000));
      write_modulus(W'(1));
      send_value(W'(5));
      send_value('0);
      write_modulus('0);
      send_value(W'(7));
      send_value('0);
      // Consecutive Fibonacci numbers give the longest quotient chain.
      write_modulus(W'(1836311903));
      send_value(W'(1134903170));

      for (phase = 0; phase < 9; phase++) begin
         case (phase)
            0: m = MOD_MAX;
            1: m = W'($urandom_range(2, 255));
            2: m = W'(2);
            3: m = W'($urandom);
            4: m = W'(1000003);
            5: m = W'($urandom) & ~W'(1);
            6: m = W'(65536);
            7: m = W'($urandom);
            default: m = MOD_MAX - W'(1);
         endcase
         if (m < W'(2)) m = W'(2);
         write_modulus(m);
         idle_enabled = (phase % 3 != 1) && (phase != 8);
         for (n = 0; n < 150; n++) begin
            if (phase == 3 && n == 10) hold_off_pending = 1'b1;
            send_value(pick_value(active_modulus));
         end
      end

      drain_responses();
      repeat (400) @(posedge clock);
      while (sb.pending() != 0) begin
         lost = sb.expected_inverses.pop_front();
         sb.report_mismatch("missing response", '0, lost);
      end
      if (sb.error_count == 0) begin
         $display("tb_modular_inverse: done, clean");
      end else begin
         $display("tb_modular_inverse: done, errors");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("tb_modular_inverse: done, errors");
      $finish;
   end

endmodule
